/* rtl/rxqap_pkg.sv */
// Shared types and constants for the receive-queue activation policy block.
// Used by rxqap_ctrl, rxqap_dp and rx_queue_activation_policy; no dependencies.
`timescale 1ns / 1ps

package rxqap_pkg;

    // Field widths fixed by the transaction format
    localparam int unsigned QIDX_W  = 6;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned GEN_W   = 64;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned WAIT_W  = 32;
    localparam int unsigned MASK_W  = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUES_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTION_WAIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMOTION_WAIT  = 2'd3;

    // Configuration reset values
    localparam logic [WAIT_W-1:0] PROMOTION_WAIT_RST = 32'd600000;
    localparam logic [WAIT_W-1:0] DEMOTION_WAIT_RST  = 32'd3000000;

    // Per-queue mode codes
    typedef enum logic [1:0] {
        MODE_ACTIVE    = 2'd0,
        MODE_DISABLING = 2'd1,
        MODE_DISABLED  = 2'd2
    } mode_t;

    // Input transaction
    typedef struct packed {
        logic [QIDX_W-1:0] queue_index;
        logic              thread_active;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] last_change_time;
        logic [GEN_W-1:0]  hw_generation;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]        queue_state;
        logic [CNT_W-1:0]  active_count;
        logic [CNT_W-1:0]  disabled_count;
        logic [GEN_W-1:0]  sw_generation;
        logic [MASK_W-1:0] active_mask;
        logic              reconfig_needed;
    } out_item_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic capture;
        logic evaluate;
    } dp_cmd_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

endpackage

/* rtl/rxqap_ctrl.sv */
// Controller for the queue activation policy: sequences capture, compare and update.
// Depends on rxqap_pkg.
`timescale 1ns / 1ps

module rxqap_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output rxqap_pkg::dp_cmd_t cmd
);

    rxqap_pkg::state_t state_reg;
    rxqap_pkg::state_t state_next;
    logic              done_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd.capture  = start && (state_reg == rxqap_pkg::ST_IDLE);
        cmd.evaluate = (state_reg == rxqap_pkg::ST_EVAL);
    end

    // Advance one step per cycle once a transaction is taken
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rxqap_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rxqap_pkg::ST_READ;
                end
            end
            rxqap_pkg::ST_READ:
            begin
                state_next = rxqap_pkg::ST_EVAL;
            end
            rxqap_pkg::ST_EVAL:
            begin
                state_next = rxqap_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rxqap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rxqap_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.evaluate;
        end
    end

    assign busy = (state_reg != rxqap_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

/* rtl/rxqap_dp.sv */
// Datapath for the queue activation policy: configuration, per-queue stores,
// shared counters and the result register. Depends on rxqap_pkg.
`timescale 1ns / 1ps

module rxqap_dp
#(
    parameter int unsigned MAX_QUEUES = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rxqap_pkg::dp_cmd_t                  cmd,
    input  rxqap_pkg::in_item_t                 req,
    input  logic                                cfg_we,
    input  logic [rxqap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rxqap_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rxqap_pkg::out_item_t                rsp
);

    localparam int unsigned QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam logic [rxqap_pkg::CNT_W-1:0] MAXQ_CNT = rxqap_pkg::CNT_W'(MAX_QUEUES);

    // Configuration registers
    logic                              policy_enable_reg;
    logic [rxqap_pkg::CNT_W-1:0]       queues_in_use_reg;
    logic [rxqap_pkg::WAIT_W-1:0]      promotion_wait_reg;
    logic [rxqap_pkg::WAIT_W-1:0]      demotion_wait_reg;

    // Shared state
    logic [rxqap_pkg::CNT_W-1:0]       active_total_reg;
    logic [rxqap_pkg::CNT_W-1:0]       disabled_total_reg;
    logic [rxqap_pkg::GEN_W-1:0]       sw_gen_reg;
    logic [MAX_QUEUES-1:0]             active_bits_reg;
    logic [MAX_QUEUES-1:0]             mode_valid_reg;

    // Per-queue memories
    rxqap_pkg::mode_t                  mode_mem [MAX_QUEUES];
    logic [rxqap_pkg::GEN_W-1:0]       gen_mem  [MAX_QUEUES];

    // Captured transaction and read data
    rxqap_pkg::in_item_t               req_reg;
    rxqap_pkg::mode_t                  mode_rd_reg;
    logic                              mode_valid_rd_reg;
    logic [rxqap_pkg::GEN_W-1:0]       gen_rd_reg;

    // Compare stage flags
    logic                              prom_gt_reg;
    logic                              dem_gt_reg;
    logic                              gen_le_reg;
    logic                              hw_lt_sw_reg;
    logic                              hw_le_sw_reg;
    logic                              sw_max_reg;
    logic                              in_range_reg;

    rxqap_pkg::out_item_t              rsp_reg;

    // Queue count write: clamp and build the all-active mask
    logic [rxqap_pkg::CNT_W-1:0]       qiu_clamped;
    logic [MAX_QUEUES-1:0]             all_mask;

    always_comb
    begin
        qiu_clamped = cfg_data[rxqap_pkg::CNT_W-1:0];
        if (qiu_clamped == '0)
        begin
            qiu_clamped = rxqap_pkg::CNT_W'(1);
        end
        if (qiu_clamped > MAXQ_CNT)
        begin
            qiu_clamped = MAXQ_CNT;
        end
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            all_mask[i] = (rxqap_pkg::CNT_W'(i) < qiu_clamped);
        end
    end

    logic qiu_write;
    assign qiu_write = cfg_we && (cfg_index == rxqap_pkg::CFG_QUEUES_IN_USE);

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_enable_reg  <= 1'b1;
            queues_in_use_reg  <= MAXQ_CNT;
            promotion_wait_reg <= rxqap_pkg::PROMOTION_WAIT_RST;
            demotion_wait_reg  <= rxqap_pkg::DEMOTION_WAIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rxqap_pkg::CFG_POLICY_ENABLE:  policy_enable_reg  <= cfg_data[0];
                rxqap_pkg::CFG_QUEUES_IN_USE:  queues_in_use_reg  <= qiu_clamped;
                rxqap_pkg::CFG_PROMOTION_WAIT: promotion_wait_reg <= cfg_data;
                rxqap_pkg::CFG_DEMOTION_WAIT:  demotion_wait_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the transaction and read both per-queue stores
    logic [QW-1:0] rd_addr;
    assign rd_addr = req.queue_index[QW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg           <= req;
            mode_rd_reg       <= mode_mem[rd_addr];
            gen_rd_reg        <= gen_mem[rd_addr];
            mode_valid_rd_reg <= mode_valid_reg[rd_addr];
        end
    end

    // Compare stage: elapsed times against the waits, generations
    logic [rxqap_pkg::TIME_W-1:0] elapsed;

    always_comb
    begin
        elapsed = req_reg.time_now - req_reg.last_change_time;
    end

    always_ff @(posedge clk)
    begin
        prom_gt_reg  <= (elapsed[rxqap_pkg::TIME_W-1:rxqap_pkg::WAIT_W] != '0)
                        || (elapsed[rxqap_pkg::WAIT_W-1:0] > promotion_wait_reg);
        dem_gt_reg   <= (elapsed[rxqap_pkg::TIME_W-1:rxqap_pkg::WAIT_W] != '0)
                        || (elapsed[rxqap_pkg::WAIT_W-1:0] > demotion_wait_reg);
        gen_le_reg   <= (gen_rd_reg <= req_reg.hw_generation);
        hw_lt_sw_reg <= (req_reg.hw_generation < sw_gen_reg);
        hw_le_sw_reg <= (req_reg.hw_generation <= sw_gen_reg);
        sw_max_reg   <= &sw_gen_reg;
        in_range_reg <= ({1'b0, req_reg.queue_index} < queues_in_use_reg);
    end

    // Update stage: decide the queue's new mode and the counters
    rxqap_pkg::mode_t             mode_cur;
    rxqap_pkg::mode_t             mode_new;
    logic [rxqap_pkg::CNT_W-1:0]  active_new;
    logic [rxqap_pkg::CNT_W-1:0]  disabled_new;
    logic [MAX_QUEUES-1:0]        bits_new;
    logic                         bump;
    logic                         demote;
    logic                         apply;
    logic [rxqap_pkg::GEN_W-1:0]  sw_inc;
    logic [QW-1:0]                wr_addr;
    logic [rxqap_pkg::MASK_W-1:0] mask_out;

    assign wr_addr = req_reg.queue_index[QW-1:0];
    assign apply   = policy_enable_reg && in_range_reg;
    assign sw_inc  = sw_gen_reg + rxqap_pkg::GEN_W'(1);

    always_comb
    begin
        mode_cur     = mode_valid_rd_reg ? mode_rd_reg : rxqap_pkg::MODE_ACTIVE;
        mode_new     = mode_cur;
        active_new   = active_total_reg;
        disabled_new = disabled_total_reg;
        bits_new     = active_bits_reg;
        bump         = 1'b0;
        demote       = 1'b0;
        if (apply)
        begin
            // Finish a pending disable once hardware caught up
            if ((mode_new == rxqap_pkg::MODE_DISABLING) && gen_le_reg)
            begin
                mode_new     = rxqap_pkg::MODE_DISABLED;
                disabled_new = disabled_new + rxqap_pkg::CNT_W'(1);
            end
            if (req_reg.thread_active)
            begin
                // Promote a queue whose thread stayed busy
                if ((mode_new != rxqap_pkg::MODE_ACTIVE) && prom_gt_reg)
                begin
                    if ((mode_new == rxqap_pkg::MODE_DISABLED) && (disabled_new != '0))
                    begin
                        disabled_new = disabled_new - rxqap_pkg::CNT_W'(1);
                    end
                    mode_new          = rxqap_pkg::MODE_ACTIVE;
                    active_new        = active_new + rxqap_pkg::CNT_W'(1);
                    bits_new[wr_addr] = 1'b1;
                    bump              = 1'b1;
                end
            end
            else
            begin
                // Demote an idle queue unless it is the last active one
                if ((active_new > rxqap_pkg::CNT_W'(1))
                    && (mode_new == rxqap_pkg::MODE_ACTIVE) && dem_gt_reg)
                begin
                    mode_new          = rxqap_pkg::MODE_DISABLING;
                    active_new        = active_new - rxqap_pkg::CNT_W'(1);
                    bits_new[wr_addr] = 1'b0;
                    bump              = 1'b1;
                    demote            = 1'b1;
                end
            end
        end
        mask_out                   = '0;
        mask_out[MAX_QUEUES-1:0]   = bits_new;
    end

    // Hold shared counters; a queue count write makes every queue in use active
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_total_reg   <= MAXQ_CNT;
            disabled_total_reg <= '0;
            sw_gen_reg         <= '0;
            active_bits_reg    <= '1;
            mode_valid_reg     <= '0;
        end
        else if (qiu_write)
        begin
            active_total_reg   <= qiu_clamped;
            disabled_total_reg <= '0;
            active_bits_reg    <= all_mask;
            mode_valid_reg     <= '0;
        end
        else if (cmd.evaluate && apply)
        begin
            active_total_reg        <= active_new;
            disabled_total_reg      <= disabled_new;
            active_bits_reg         <= bits_new;
            mode_valid_reg[wr_addr] <= 1'b1;
            if (bump)
            begin
                sw_gen_reg <= sw_inc;
            end
        end
    end

    // Write back the queue entry
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate && apply)
        begin
            mode_mem[wr_addr] <= mode_new;
            if (demote)
            begin
                gen_mem[wr_addr] <= sw_inc;
            end
        end
    end

    // Register the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate)
        begin
            rsp_reg.queue_state     <= in_range_reg ? mode_new : rxqap_pkg::MODE_ACTIVE;
            rsp_reg.active_count    <= active_new;
            rsp_reg.disabled_count  <= disabled_new;
            rsp_reg.sw_generation   <= bump ? sw_inc : sw_gen_reg;
            rsp_reg.active_mask     <= mask_out;
            rsp_reg.reconfig_needed <= bump ? (hw_le_sw_reg && !sw_max_reg) : hw_lt_sw_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* rtl/rx_queue_activation_policy.sv */
// Adaptive receive-queue activation policy, top level.
// Steps: the registered read of the per-queue stores, the compare stage and the single
// update/write-back stage; done and the result are registered at the end of the update.
// A new transaction is taken only in idle, not before the last one has finished these steps.
// Reset (async, rst_n low): control, config and counters reset; all queues active, generation 0.
// The receiver cannot stall: each result is shown for one cycle with done.
`timescale 1ns / 1ps

module rx_queue_activation_policy
#(
    parameter int unsigned MAX_QUEUES = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rxqap_pkg::in_item_t              req,
    output logic                             done,
    output rxqap_pkg::out_item_t             rsp,
    input  logic                             cfg_we,
    input  logic [rxqap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rxqap_pkg::CFG_DATA_W-1:0] cfg_data
);

    rxqap_pkg::dp_cmd_t cmd;

    rxqap_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rxqap_dp #(
        .MAX_QUEUES (MAX_QUEUES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

    // A result appears only once the controller is back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction keeps the block busy and gives no result next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not occupy the block");

    // A result strobe follows each accept after the read, compare and update steps
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##3 done)
        else $error("missing result after accept");

    // The last active queue is never demoted
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (rsp.active_count != '0))
        else $error("active queue count dropped to zero");

endmodule
